// ===== hdl/vrle_pkg.sv =====
package vrle_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int MAX_DIM_DEFAULT       = 256;

   localparam int COORD_W     = 10;
   localparam int INDEX_MAX_W = 12;

   localparam logic [7:0]         RLE_ALPHA = 8'd2;
   localparam logic [COORD_W-1:0] BOX_INIT  = 10'd1000;
   localparam logic [8:0]         SIZE_Y_MAX = 9'd256;

   localparam logic [1:0] KIND_RUN  = 2'd0;
   localparam logic [1:0] KIND_BOX  = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   typedef enum logic [1:0] {
      PH_COUNT_LO,
      PH_COUNT_HI,
      PH_WORD,
      PH_COLOR
   } phase_type;

   typedef enum logic {
      CTL_READY,
      CTL_WAIT
   } ctl_state_type;

   typedef enum logic {
      PLT_IDLE,
      PLT_SEARCH
   } plt_state_type;

   typedef struct packed {
      logic                   done;
      logic                   full;
      logic                   is_new;
      logic [INDEX_MAX_W-1:0] index;
   } plt_result_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] first_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_z;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_z;
      logic [7:0]         color_index;
      logic               color_new;
      logic [31:0]        color_rgba;
   } rsp_payload_type;

endpackage

// ===== hdl/vrle_req_if.sv =====
interface vrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, data_byte, end_of_stream, input ready);
   modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

// ===== hdl/vrle_rsp_if.sv =====
interface vrle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [9:0]  first_x;
   logic [9:0]  first_y;
   logic [9:0]  first_z;
   logic [9:0]  second_x;
   logic [9:0]  second_y;
   logic [9:0]  second_z;
   logic [7:0]  color_index;
   logic        color_new;
   logic [31:0] color_rgba;

   modport source (output valid, kind, first_x, first_y, first_z, second_x, second_y,
                   second_z, color_index, color_new, color_rgba, input ready);
   modport sink   (input valid, kind, first_x, first_y, first_z, second_x, second_y,
                   second_z, color_index, color_new, color_rgba, output ready);
endinterface

// ===== hdl/vrle_ram.sv =====
module vrle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/vrle_palette.sv =====
module vrle_palette #(
   parameter int PALETTE_DEPTH = vrle_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              color,
   output vrle_pkg::plt_result_type result
);
   import vrle_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int CW = $clog2(PALETTE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

   plt_state_type state_ff, state_in;
   logic [31:0]   color_ff, color_in;
   logic [CW-1:0] next_ff, next_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   logic [CW-1:0] count_ff, count_in;

   logic          rd_en;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic          hit;
   logic          exhausted;
   logic          finish;

   assign hit       = pend_valid_ff && (rd_data == color_ff);
   assign exhausted = (next_ff == count_ff);
   assign finish    = (state_ff == PLT_SEARCH) && (hit || exhausted);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PLT_IDLE: begin
            if (start) begin
               state_in = PLT_SEARCH;
            end
         end
         PLT_SEARCH: begin
            if (finish) begin
               state_in = PLT_IDLE;
            end
         end
         default: state_in = PLT_IDLE;
      endcase
   end

   always_comb begin
      rd_en         = (state_ff == PLT_SEARCH) && !exhausted;
      wr_en         = finish && !hit && (count_ff != DEPTH_C);
      result.done   = finish;
      result.full   = finish && !hit && (count_ff == DEPTH_C);
      result.is_new = wr_en;
      result.index  = hit ? INDEX_MAX_W'(pend_idx_ff) : INDEX_MAX_W'(count_ff);
   end

   always_comb begin
      color_in      = color_ff;
      next_in       = next_ff;
      pend_valid_in = 1'b0;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      if (state_ff == PLT_IDLE && start) begin
         color_in = color;
         next_in  = '0;
      end
      if (rd_en) begin
         next_in       = next_ff + 1'b1;
         pend_valid_in = 1'b1;
         pend_idx_in   = next_ff[AW-1:0];
      end
      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PLT_IDLE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         next_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         next_ff       <= next_in;
      end
      color_ff    <= color_in;
      pend_idx_ff <= pend_idx_in;
   end

   vrle_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_DEPTH)
   ) u_colors (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (color_ff),
      .rd_en   (rd_en),
      .rd_addr (next_ff[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

// ===== hdl/voxel_rle_column_decoder_top.sv =====
// Decodes inflated voxel column data, one byte per transaction, into coloured z runs
// with first-use palette indices, and reports the bounding box on an end-of-stream
// transaction. After count bytes, partial word bytes, markers, hidden or clipped runs
// and the end-of-stream transaction the next byte can be taken, unless a response is
// still waiting. A word that completes a visible run starts a search of the palette
// memory through its single read port, one entry per cycle; no byte is taken until
// the search ends. The palette is kept across streams and emptied only by reset.
module voxel_rle_column_decoder_top #(
   parameter int PALETTE_DEPTH = vrle_pkg::PALETTE_DEPTH_DEFAULT,
   parameter int MAX_DIM       = vrle_pkg::MAX_DIM_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data,
   vrle_req_if.sink   req,
   vrle_rsp_if.source rsp
);
   import vrle_pkg::*;

   localparam logic [COORD_W-1:0] DIM_LIMIT = COORD_W'(MAX_DIM);
   localparam logic [COORD_W-1:0] DIM_LAST  = COORD_W'(MAX_DIM - 1);

   logic [8:0]         size_y_ff, size_y_in;
   ctl_state_type      ctl_ff, ctl_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         bpos_ff, bpos_in;
   logic [31:0]        asm_ff, asm_in;
   logic [15:0]        wl_ff, wl_in;
   logic [7:0]         repeat_ff, repeat_in;
   logic [7:0]         row_ff, row_in;
   logic [COORD_W-1:0] slice_ff, slice_in;
   logic [COORD_W-1:0] depth_ff, depth_in;
   logic [COORD_W-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in, min_z_ff, min_z_in;
   logic [COORD_W-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in, max_z_ff, max_z_in;
   logic [COORD_W-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [COORD_W-1:0] pend_z0_ff, pend_z0_in, pend_z1_ff, pend_z1_in;
   logic [31:0]        pend_color_ff, pend_color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               accept;
   logic               plt_start;
   plt_result_type     plt_res;

   logic [8:0]         eff_y;
   logic [8:0]         flip_y;
   logic [31:0]        word;
   logic [15:0]        wl_dec;
   logic [7:0]         run_len;
   logic [COORD_W:0]   z_sum;
   logic [COORD_W:0]   z_end;
   logic [8:0]         row_inc;
   logic               visible;
   logic               col_end;
   logic               start_search;

   assign accept = req.valid && req.ready;

   always_comb begin
      if (size_y_ff == 9'd0) begin
         eff_y = 9'd1;
      end else if (size_y_ff > SIZE_Y_MAX) begin
         eff_y = SIZE_Y_MAX;
      end else begin
         eff_y = size_y_ff;
      end
   end

   assign flip_y  = eff_y - {1'b0, row_ff};
   assign word    = asm_ff | (32'(req.data_byte) << {bpos_ff, 3'b000});
   assign wl_dec  = (wl_ff != 16'd0) ? wl_ff - 16'd1 : wl_ff;
   assign run_len = (phase_ff == PH_COLOR) ? repeat_ff : 8'd1;
   assign z_sum   = {1'b0, depth_ff} + (COORD_W + 1)'(run_len);
   assign z_end   = z_sum - 1'b1;
   assign row_inc = {1'b0, row_ff} + 9'd1;
   assign visible = (run_len != 8'd0) && (word[31:24] != 8'd0) && (slice_ff < DIM_LIMIT)
                    && ({1'b0, row_ff} <= eff_y)
                    && ({1'b0, flip_y} < DIM_LIMIT) && (depth_ff < DIM_LIMIT);

   always_comb begin
      size_y_in     = csr_write_enable ? csr_write_data : size_y_ff;
      phase_in      = phase_ff;
      bpos_in       = bpos_ff;
      asm_in        = asm_ff;
      wl_in         = wl_ff;
      repeat_in     = repeat_ff;
      row_in        = row_ff;
      slice_in      = slice_ff;
      depth_in      = depth_ff;
      min_x_in      = min_x_ff;
      min_y_in      = min_y_ff;
      min_z_in      = min_z_ff;
      max_x_in      = max_x_ff;
      max_y_in      = max_y_ff;
      max_z_in      = max_z_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_z0_in    = pend_z0_ff;
      pend_z1_in    = pend_z1_ff;
      pend_color_in = pend_color_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_in        = rsp_ff;
      col_end       = 1'b0;
      start_search  = 1'b0;

      if (accept && req.end_of_stream) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.kind        = KIND_BOX;
         rsp_in.first_x     = min_x_ff;
         rsp_in.first_y     = min_y_ff;
         rsp_in.first_z     = min_z_ff;
         rsp_in.second_x    = max_x_ff;
         rsp_in.second_y    = max_y_ff;
         rsp_in.second_z    = max_z_ff;
         phase_in  = PH_COUNT_LO;
         bpos_in   = 2'd0;
         asm_in    = '0;
         wl_in     = '0;
         repeat_in = '0;
         row_in    = '0;
         slice_in  = '0;
         depth_in  = '0;
         min_x_in  = BOX_INIT;
         min_y_in  = BOX_INIT;
         min_z_in  = BOX_INIT;
         max_x_in  = '0;
         max_y_in  = '0;
         max_z_in  = '0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_COUNT_LO: begin
               wl_in    = {8'd0, req.data_byte};
               phase_in = PH_COUNT_HI;
            end
            PH_COUNT_HI: begin
               wl_in    = {req.data_byte, wl_ff[7:0]};
               depth_in = '0;
               bpos_in  = 2'd0;
               asm_in   = '0;
               if ({req.data_byte, wl_ff[7:0]} == 16'd0) begin
                  col_end = 1'b1;
               end else begin
                  phase_in = PH_WORD;
               end
            end
            PH_WORD, PH_COLOR: begin
               asm_in  = word;
               bpos_in = bpos_ff + 2'd1;
               if (bpos_ff == 2'd3) begin
                  asm_in = '0;
                  wl_in  = wl_dec;
                  if (phase_ff == PH_WORD && word[31:24] == RLE_ALPHA) begin
                     repeat_in = word[7:0];
                     phase_in  = PH_COLOR;
                  end else begin
                     depth_in      = (z_sum >= {1'b0, DIM_LIMIT}) ? DIM_LIMIT
                                                                 : z_sum[COORD_W-1:0];
                     pend_x_in     = slice_ff;
                     pend_y_in     = COORD_W'(flip_y);
                     pend_z0_in    = depth_ff;
                     pend_z1_in    = (z_end > {1'b0, DIM_LAST}) ? DIM_LAST
                                                               : z_end[COORD_W-1:0];
                     pend_color_in = word;
                     start_search  = visible;
                     if (wl_dec == 16'd0) begin
                        col_end = 1'b1;
                     end else begin
                        phase_in = PH_WORD;
                     end
                  end
               end
            end
            default: phase_in = PH_COUNT_LO;
         endcase
      end

      if (col_end) begin
         phase_in = PH_COUNT_LO;
         depth_in = '0;
         if (row_inc >= eff_y) begin
            row_in = '0;
            if (slice_ff < DIM_LIMIT) begin
               slice_in = slice_ff + 1'b1;
            end
         end else begin
            row_in = row_inc[7:0];
         end
      end

      if (plt_res.done) begin
         rsp_valid_in       = 1'b1;
         rsp_in.first_x     = pend_x_ff;
         rsp_in.first_y     = pend_y_ff;
         rsp_in.first_z     = pend_z0_ff;
         rsp_in.second_x    = pend_x_ff;
         rsp_in.second_y    = pend_y_ff;
         rsp_in.second_z    = pend_z1_ff;
         rsp_in.color_rgba  = pend_color_ff;
         if (plt_res.full) begin
            rsp_in.kind        = KIND_FULL;
            rsp_in.color_index = 8'd0;
            rsp_in.color_new   = 1'b0;
         end else begin
            rsp_in.kind        = KIND_RUN;
            rsp_in.color_index = plt_res.index[7:0];
            rsp_in.color_new   = plt_res.is_new;
            if (pend_x_ff < min_x_ff) min_x_in = pend_x_ff;
            if (pend_y_ff < min_y_ff) min_y_in = pend_y_ff;
            if (pend_z0_ff < min_z_ff) min_z_in = pend_z0_ff;
            if (pend_x_ff > max_x_ff) max_x_in = pend_x_ff;
            if (pend_y_ff > max_y_ff) max_y_in = pend_y_ff;
            if (pend_z1_ff > max_z_ff) max_z_in = pend_z1_ff;
         end
      end
   end

   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         CTL_READY: begin
            if (start_search) begin
               ctl_in = CTL_WAIT;
            end
         end
         CTL_WAIT: begin
            if (plt_res.done) begin
               ctl_in = CTL_READY;
            end
         end
         default: ctl_in = CTL_READY;
      endcase
   end

   always_comb begin
      req.ready = (ctl_ff == CTL_READY) && (!rsp_valid_ff || rsp.ready);
      plt_start = start_search;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_y_ff    <= 9'd1;
         ctl_ff       <= CTL_READY;
         phase_ff     <= PH_COUNT_LO;
         bpos_ff      <= 2'd0;
         asm_ff       <= '0;
         wl_ff        <= '0;
         repeat_ff    <= '0;
         row_ff       <= '0;
         slice_ff     <= '0;
         depth_ff     <= '0;
         min_x_ff     <= BOX_INIT;
         min_y_ff     <= BOX_INIT;
         min_z_ff     <= BOX_INIT;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         max_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_y_ff    <= size_y_in;
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         bpos_ff      <= bpos_in;
         asm_ff       <= asm_in;
         wl_ff        <= wl_in;
         repeat_ff    <= repeat_in;
         row_ff       <= row_in;
         slice_ff     <= slice_in;
         depth_ff     <= depth_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         min_z_ff     <= min_z_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         max_z_ff     <= max_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      pend_z0_ff    <= pend_z0_in;
      pend_z1_ff    <= pend_z1_in;
      pend_color_ff <= pend_color_in;
      rsp_ff        <= rsp_in;
   end

   vrle_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .reset  (reset),
      .start  (plt_start),
      .color  (word),
      .result (plt_res)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_ff.kind;
   assign rsp.first_x     = rsp_ff.first_x;
   assign rsp.first_y     = rsp_ff.first_y;
   assign rsp.first_z     = rsp_ff.first_z;
   assign rsp.second_x    = rsp_ff.second_x;
   assign rsp.second_y    = rsp_ff.second_y;
   assign rsp.second_z    = rsp_ff.second_z;
   assign rsp.color_index = rsp_ff.color_index;
   assign rsp.color_new   = rsp_ff.color_new;
   assign rsp.color_rgba  = rsp_ff.color_rgba;

   a_wait_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ctl_ff == CTL_WAIT |-> !req.ready)
      else $error("input taken during palette search");

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      plt_res.done |-> ctl_ff == CTL_WAIT)
      else $error("palette result without a pending run");

   a_box_reported: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_stream |=> rsp_valid_ff && rsp_ff.kind == KIND_BOX)
      else $error("bounding box transaction not presented");

endmodule
